[rtl/prdf_pkg.sv]
// Package for the paired-read duplicate filter: payload structs, result kinds,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package prdf_pkg;

  localparam int unsigned GROUP_DEPTH_DEF    = 32;
  localparam int unsigned NAME_SET_DEPTH_DEF = 4096;
  localparam int unsigned CNT_W              = 40;
  localparam int unsigned UNM_W              = 13;

  typedef enum logic [1:0] {
    KIND_KEPT      = 2'd0,
    KIND_UNMATCHED = 2'd1,
    KIND_STATS     = 2'd2
  } kind_e;

  typedef struct packed {
    logic               mode;
    logic [15:0]        ref_id;
    logic [31:0]        pos;
    logic signed [31:0] dist_req;
    logic [7:0]         read_size;
    logic [7:0]         map_quality;
    logic [63:0]        name_key;
    logic [31:0]        record_tag;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [31:0]       kept_tag;
    logic [UNM_W-1:0]  unmatched_count;
    logic [CNT_W-1:0]  checked_count;
    logic [CNT_W-1:0]  removed_count;
    logic              last;
  } out_item_t;

  // One stored pair head of the current position group
  typedef struct packed {
    logic [31:0]        pos;
    logic signed [31:0] mate_dist;
    logic [7:0]         qual;
    logic [63:0]        name;
    logic [31:0]        tag;
  } head_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FL_RD,
    ST_FL_PUSH,
    ST_REFCHK,
    ST_UNM,
    ST_CLASS,
    ST_G_RD,
    ST_G_CMP,
    ST_HEAD_MISS,
    ST_S_RD,
    ST_S_CMP,
    ST_S_LAST_RD,
    ST_S_LAST_WR,
    ST_ADD_APPEND,
    ST_ADD_OK,
    ST_KEEP,
    ST_STATS,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic  load;
    logic  push;
    kind_e push_kind;
    logic  push_grp;     // kept tag comes from the group read port
    logic  finish;
    logic  set_ref;
    logic  set_grp;
    logic  clr_gcount;
    logic  gidx_clr;
    logic  gidx_inc;
    logic  g_latch_hit;
    logic  g_append;
    logic  g_replace;
    logic  chk_inc;
    logic  rem_inc;
    logic  sidx_clr;
    logic  sidx_inc;
    logic  s_rd_last;
    logic  s_append;
    logic  s_move;
    logic  nclr;
  } dp_cmd_t;

  typedef struct packed {
    logic can_push;
    logic is_end;
    logic newref;
    logic grpchg;
    logic keep;
    logic is_head;
    logic gcount_zero;
    logic gcount_full;
    logic ncount_zero;
    logic ncount_full;
    logic g_match;
    logic g_last;
    logic s_match;
    logic s_last;
    logic replace;
  } dp_stat_t;

endpackage

[rtl/paired_read_duplicate_filter.sv]
// Top level of the paired-read duplicate filter: controller plus datapath.
// Depends on prdf_pkg, prdf_ctrl and prdf_dp.
//
// Usage: position-sorted alignment records, or an end-of-stream beat (mode 1),
// enter on the in channel (valid/stall); result beats leave on the out channel,
// the final result of each input carrying last. One item is worked at a time.
// A record kept at once passes accept, decide, reference check, classify, keep and
// finish; further steps come with each stored head scanned, each deleted name
// scanned, each head emitted at a group change, an unmatched report and the erasing
// of a name, as the group and name-set memories are read through single ports.
// Each result waits one stage until its last flag is known.
// The next item is accepted once the current one is done, even while its last
// result still waits in the output register. A stalled receiver holds the
// output beat; the block then waits with at most one staged result held back.
// Reset clears all control state: no reference, empty group and empty name set
// (held by a fill count, so no clearing pass is needed), counters at zero.
module paired_read_duplicate_filter #(
  parameter int unsigned GROUP_DEPTH    = prdf_pkg::GROUP_DEPTH_DEF,
  parameter int unsigned NAME_SET_DEPTH = prdf_pkg::NAME_SET_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prdf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prdf_pkg::out_item_t out_data_o
);
  import prdf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prdf_dp #(
    .GROUP_DEPTH    (GROUP_DEPTH),
    .NAME_SET_DEPTH (NAME_SET_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/prdf_dp.sv]
// Datapath of the duplicate filter: item register, group head memory, deleted-name
// memory, counters and the hold/output result registers. Depends on prdf_pkg.
module prdf_dp #(
  parameter int unsigned GROUP_DEPTH    = prdf_pkg::GROUP_DEPTH_DEF,
  parameter int unsigned NAME_SET_DEPTH = prdf_pkg::NAME_SET_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prdf_pkg::in_item_t  in_data_i,
  input  prdf_pkg::dp_cmd_t   cmd_i,
  output prdf_pkg::dp_stat_t  stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output prdf_pkg::out_item_t out_data_o
);
  import prdf_pkg::*;

  localparam int unsigned GW  = $clog2(GROUP_DEPTH);
  localparam int unsigned GCW = $clog2(GROUP_DEPTH + 1);
  localparam int unsigned SW  = $clog2(NAME_SET_DEPTH);
  localparam int unsigned NCW = $clog2(NAME_SET_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  in_item_t item_q;
  logic have_ref_q;
  logic [15:0] cur_ref_q;
  logic [30:0] gpos_q;
  logic [GCW-1:0] gcount_q;
  logic [NCW-1:0] ncount_q;
  logic [GW-1:0] gidx_q;
  logic [SW-1:0] sidx_q;
  logic [CNT_W-1:0] checked_q, removed_q;
  logic [63:0] cand_q;
  logic repl_q;

  head_t gmem [GROUP_DEPTH];
  head_t g_rd_q;
  logic [63:0] smem [NAME_SET_DEPTH];
  logic [63:0] s_rd_q;

  // Item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  // Record classification
  logic [32:0] dx, mag;
  logic keep;
  assign dx   = {item_q.dist_req[31], item_q.dist_req};
  assign mag  = item_q.dist_req[31] ? (33'd0 - dx) : dx;
  assign keep = (item_q.dist_req == 32'sd0) || (mag <= {25'd0, item_q.read_size});

  // Group head memory
  head_t g_wdata;
  logic [GW-1:0] g_waddr;
  always_comb begin
    g_wdata.pos       = item_q.pos;
    g_wdata.mate_dist = item_q.dist_req;
    g_wdata.qual      = item_q.map_quality;
    g_wdata.name      = item_q.name_key;
    g_wdata.tag       = item_q.record_tag;
    g_waddr = cmd_i.g_append ? gcount_q[GW-1:0] : gidx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.g_append || cmd_i.g_replace) begin
      gmem[g_waddr] <= g_wdata;
    end
    g_rd_q <= gmem[gidx_q];
  end

  // Deleted-name memory, kept compact with a fill count
  logic [NCW-1:0] nlast;
  logic [SW-1:0] s_raddr, s_waddr;
  logic [63:0] s_wdata;
  assign nlast   = ncount_q - NCW'(1);
  assign s_raddr = cmd_i.s_rd_last ? nlast[SW-1:0] : sidx_q;
  assign s_waddr = cmd_i.s_append ? ncount_q[SW-1:0] : sidx_q;
  assign s_wdata = cmd_i.s_append ? cand_q : s_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_append || cmd_i.s_move) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rd_q <= smem[s_raddr];
  end

  // Candidate name for the deleted set, taken at a group hit
  always_ff @(posedge clk_i) begin
    if (cmd_i.g_latch_hit) begin
      repl_q <= g_rd_q.qual < item_q.map_quality;
      cand_q <= (g_rd_q.qual < item_q.map_quality) ? g_rd_q.name : item_q.name_key;
    end
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_ref_q <= 1'b0;
      cur_ref_q  <= '0;
      gpos_q     <= '1;
      gcount_q   <= '0;
      ncount_q   <= '0;
      gidx_q     <= '0;
      sidx_q     <= '0;
      checked_q  <= '0;
      removed_q  <= '0;
    end else begin
      if (cmd_i.set_ref) begin
        have_ref_q <= 1'b1;
        cur_ref_q  <= item_q.ref_id;
      end
      if (cmd_i.set_grp) gpos_q <= item_q.pos[31:1];
      if (cmd_i.clr_gcount) begin
        gcount_q <= '0;
      end else if (cmd_i.g_append) begin
        gcount_q <= gcount_q + GCW'(1);
      end
      if (cmd_i.nclr) begin
        ncount_q <= '0;
      end else if (cmd_i.s_append) begin
        ncount_q <= ncount_q + NCW'(1);
      end else if (cmd_i.s_move) begin
        ncount_q <= nlast;
      end
      if (cmd_i.gidx_clr) begin
        gidx_q <= '0;
      end else if (cmd_i.gidx_inc) begin
        gidx_q <= gidx_q + GW'(1);
      end
      if (cmd_i.sidx_clr) begin
        sidx_q <= '0;
      end else if (cmd_i.sidx_inc) begin
        sidx_q <= sidx_q + SW'(1);
      end
      if (cmd_i.chk_inc && checked_q != CNT_MAX) checked_q <= checked_q + CNT_W'(1);
      if (cmd_i.rem_inc && removed_q != CNT_MAX) removed_q <= removed_q + CNT_W'(1);
    end
  end

  // Result staging: hold one result back until its last flag is known
  logic hold_v_q, hold_v_d, out_v_q, out_v_d;
  out_item_t hold_q, hold_d, out_q, out_d, new_res;
  logic [31:0] nc32;
  assign nc32 = 32'(ncount_q);

  always_comb begin
    new_res = '0;
    new_res.kind = cmd_i.push_kind;
    case (cmd_i.push_kind)
      KIND_KEPT:      new_res.kept_tag = cmd_i.push_grp ? g_rd_q.tag : item_q.record_tag;
      KIND_UNMATCHED: new_res.unmatched_count = nc32[UNM_W-1:0];
      KIND_STATS: begin
        new_res.checked_count = checked_q;
        new_res.removed_count = removed_q;
      end
      default: new_res = '0;
    endcase
  end

  // Next values of the staging registers
  always_comb begin
    hold_v_d = hold_v_q;
    out_v_d  = out_v_q && out_stall_i;
    hold_d   = hold_q;
    out_d    = out_q;
    if (cmd_i.push) begin
      hold_v_d = 1'b1;
      hold_d   = new_res;
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = hold_q;
      end
    end else if (cmd_i.finish && hold_v_q) begin
      hold_v_d   = 1'b0;
      out_v_d    = 1'b1;
      out_d      = hold_q;
      out_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Status to the controller
  always_comb begin
    stat_o.can_push    = !hold_v_q || !out_v_q || !out_stall_i;
    stat_o.is_end      = item_q.mode;
    stat_o.newref      = !have_ref_q || (item_q.ref_id != cur_ref_q);
    stat_o.grpchg      = item_q.pos[31:1] != gpos_q;
    stat_o.keep        = keep;
    stat_o.is_head     = !keep && !item_q.dist_req[31];
    stat_o.gcount_zero = gcount_q == '0;
    stat_o.gcount_full = gcount_q == GCW'(GROUP_DEPTH);
    stat_o.ncount_zero = ncount_q == '0;
    stat_o.ncount_full = ncount_q == NCW'(NAME_SET_DEPTH);
    stat_o.g_match     = (g_rd_q.pos == item_q.pos) && (g_rd_q.mate_dist == item_q.dist_req);
    stat_o.g_last      = (GCW'(gidx_q) + GCW'(1)) == gcount_q;
    stat_o.s_match     = s_rd_q == (stat_o.is_head ? cand_q : item_q.name_key);
    stat_o.s_last      = (NCW'(sidx_q) + NCW'(1)) == ncount_q;
    stat_o.replace     = repl_q;
  end

endmodule

[rtl/prdf_ctrl.sv]
// Controller of the duplicate filter: sequences flushes, group and name-set scans
// and result pushes. Depends on prdf_pkg.
module prdf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  prdf_pkg::dp_stat_t stat_i,
  output prdf_pkg::dp_cmd_t  cmd_o
);
  import prdf_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.push_kind = KIND_KEPT;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.gidx_clr = 1'b1;
        if (stat_i.is_end) begin
          state_d = stat_i.gcount_zero ? ST_STATS : ST_FL_RD;
        end else if ((stat_i.newref || stat_i.grpchg) && !stat_i.gcount_zero) begin
          state_d = ST_FL_RD;
        end else begin
          state_d = ST_REFCHK;
        end
      end
      ST_FL_RD: state_d = ST_FL_PUSH;
      ST_FL_PUSH: begin
        if (stat_i.can_push) begin
          cmd_o.push     = 1'b1;
          cmd_o.push_grp = 1'b1;
          if (stat_i.g_last) begin
            cmd_o.clr_gcount = 1'b1;
            cmd_o.gidx_clr   = 1'b1;
            state_d = stat_i.is_end ? ST_STATS : ST_REFCHK;
          end else begin
            cmd_o.gidx_inc = 1'b1;
            state_d = ST_FL_RD;
          end
        end
      end
      ST_REFCHK: begin
        cmd_o.set_grp = 1'b1;
        if (stat_i.newref) begin
          cmd_o.set_ref = 1'b1;
          state_d = stat_i.ncount_zero ? ST_CLASS : ST_UNM;
        end else begin
          state_d = ST_CLASS;
        end
      end
      ST_UNM: begin
        if (stat_i.can_push) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_UNMATCHED;
          cmd_o.nclr      = 1'b1;
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd_o.sidx_clr = 1'b1;
        cmd_o.gidx_clr = 1'b1;
        if (stat_i.keep) begin
          state_d = ST_KEEP;
        end else if (stat_i.is_head) begin
          cmd_o.chk_inc = 1'b1;
          state_d = stat_i.gcount_zero ? ST_HEAD_MISS : ST_G_RD;
        end else begin
          state_d = stat_i.ncount_zero ? ST_KEEP : ST_S_RD;
        end
      end
      ST_G_RD: state_d = ST_G_CMP;
      ST_G_CMP: begin
        if (stat_i.g_match) begin
          cmd_o.g_latch_hit = 1'b1;
          state_d = stat_i.ncount_zero ? ST_ADD_APPEND : ST_S_RD;
        end else if (stat_i.g_last) begin
          state_d = ST_HEAD_MISS;
        end else begin
          cmd_o.gidx_inc = 1'b1;
          state_d = ST_G_RD;
        end
      end
      ST_HEAD_MISS: begin
        if (!stat_i.gcount_full) begin
          cmd_o.g_append = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_KEEP;
        end
      end
      ST_S_RD: state_d = ST_S_CMP;
      ST_S_CMP: begin
        if (stat_i.s_match) begin
          state_d = stat_i.is_head ? ST_ADD_OK : ST_S_LAST_RD;
        end else if (stat_i.s_last) begin
          state_d = stat_i.is_head ? ST_ADD_APPEND : ST_KEEP;
        end else begin
          cmd_o.sidx_inc = 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_S_LAST_RD: begin
        cmd_o.s_rd_last = 1'b1;
        state_d = ST_S_LAST_WR;
      end
      // move the last name into the erased slot
      ST_S_LAST_WR: begin
        cmd_o.s_move = 1'b1;
        state_d = ST_FIN;
      end
      ST_ADD_APPEND: begin
        if (!stat_i.ncount_full) begin
          cmd_o.s_append = 1'b1;
          state_d = ST_ADD_OK;
        end else begin
          state_d = ST_KEEP;
        end
      end
      ST_ADD_OK: begin
        cmd_o.rem_inc   = 1'b1;
        cmd_o.g_replace = stat_i.replace;
        state_d = ST_FIN;
      end
      ST_KEEP: begin
        if (stat_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_STATS: begin
        if (stat_i.can_push) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_STATS;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat_i.can_push) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[bench/prdf_checker.sv]
// Result checker for the paired-read duplicate filter: watches both channels,
// predicts result beats from accepted input beats and compares them in order.
// Depends on prdf_pkg.
`timescale 1ns / 1ps
module prdf_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  prdf_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  prdf_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import prdf_pkg::*;

  localparam int unsigned GDEPTH = GROUP_DEPTH_DEF;
  localparam int unsigned NDEPTH = NAME_SET_DEPTH_DEF;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // predictor state
  logic              ref_seen;
  logic [15:0]       cur_ref;
  logic [30:0]       cur_grp;
  head_t             heads[GDEPTH];
  int unsigned       head_cnt;
  logic [63:0]       dropped[$];
  logic [CNT_W-1:0]  heads_checked;
  logic [CNT_W-1:0]  dups_removed;

  out_item_t         expected_beats[$];

  function automatic out_item_t mk_beat(kind_e k, logic [31:0] tag,
                                        logic [UNM_W-1:0] unm,
                                        logic [CNT_W-1:0] chk,
                                        logic [CNT_W-1:0] rem);
    out_item_t b;
    b.kind = k;
    b.kept_tag = tag;
    b.unmatched_count = unm;
    b.checked_count = chk;
    b.removed_count = rem;
    b.last = 1'b0;
    return b;
  endfunction

  function automatic int find_dropped(logic [63:0] nm);
    foreach (dropped[i]) if (dropped[i] == nm) return i;
    return -1;
  endfunction

  task automatic emit_group(inout out_item_t q[$]);
    for (int i = 0; i < head_cnt; i++)
      q.push_back(mk_beat(KIND_KEPT, heads[i].tag, '0, '0, '0));
    head_cnt = 0;
  endtask

  // Work out the result beats of one accepted input beat
  task automatic predict_filter(in_item_t it);
    out_item_t         q[$];
    logic              new_ref;
    longint            d;
    longint            mag;
    int                hit;
    int                k;
    logic              repl;
    logic [63:0]       loser;
    logic              added;
    if (it.mode) begin
      emit_group(q);
      q.push_back(mk_beat(KIND_STATS, '0, '0, heads_checked, dups_removed));
    end else begin
      new_ref = !ref_seen || it.ref_id != cur_ref;
      if (new_ref || it.pos[31:1] != cur_grp) begin
        emit_group(q);
        if (new_ref) begin
          if (dropped.size() != 0) begin
            q.push_back(mk_beat(KIND_UNMATCHED, '0, UNM_W'(dropped.size()), '0, '0));
            dropped.delete();
          end
          ref_seen = 1'b1;
          cur_ref = it.ref_id;
        end
      end
      cur_grp = it.pos[31:1];
      d = longint'(it.dist_req);
      mag = d < 0 ? -d : d;
      if (d == 0 || mag <= longint'(it.read_size)) begin
        q.push_back(mk_beat(KIND_KEPT, it.record_tag, '0, '0, '0));
      end else if (d > 0) begin
        if (heads_checked != CNT_SAT) heads_checked++;
        hit = -1;
        for (int i = 0; i < head_cnt; i++)
          if (hit < 0 && heads[i].pos == it.pos && heads[i].mate_dist == it.dist_req)
            hit = i;
        if (hit >= 0) begin
          repl = heads[hit].qual < it.map_quality;
          loser = repl ? heads[hit].name : it.name_key;
          added = 1'b1;
          if (find_dropped(loser) < 0) begin
            if (dropped.size() >= NDEPTH) added = 1'b0;
            else dropped.push_back(loser);
          end
          if (added) begin
            if (dups_removed != CNT_SAT) dups_removed++;
            if (repl) begin
              heads[hit].qual = it.map_quality;
              heads[hit].name = it.name_key;
              heads[hit].tag = it.record_tag;
            end
          end else begin
            q.push_back(mk_beat(KIND_KEPT, it.record_tag, '0, '0, '0));
          end
        end else if (head_cnt < GDEPTH) begin
          heads[head_cnt].pos = it.pos;
          heads[head_cnt].mate_dist = it.dist_req;
          heads[head_cnt].qual = it.map_quality;
          heads[head_cnt].name = it.name_key;
          heads[head_cnt].tag = it.record_tag;
          head_cnt++;
        end else begin
          q.push_back(mk_beat(KIND_KEPT, it.record_tag, '0, '0, '0));
        end
      end else begin
        // tail: a dropped mate's name is erased by moving the last entry in
        k = find_dropped(it.name_key);
        if (k >= 0) begin
          dropped[k] = dropped[dropped.size() - 1];
          void'(dropped.pop_back());
        end else begin
          q.push_back(mk_beat(KIND_KEPT, it.record_tag, '0, '0, '0));
        end
      end
    end
    if (q.size() > 0) q[q.size() - 1].last = 1'b1;
    foreach (q[i]) expected_beats.push_back(q[i]);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic compare_beat(out_item_t got);
    out_item_t e;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %p", got));
      return;
    end
    e = expected_beats.pop_front();
    if (got.kind !== e.kind)
      report_mismatch($sformatf("kind %0d want %0d", got.kind, e.kind));
    if (got.kept_tag !== e.kept_tag)
      report_mismatch($sformatf("kept_tag %h want %h", got.kept_tag, e.kept_tag));
    if (got.unmatched_count !== e.unmatched_count)
      report_mismatch($sformatf("unmatched %0d want %0d",
                                got.unmatched_count, e.unmatched_count));
    if (got.checked_count !== e.checked_count)
      report_mismatch($sformatf("checked %0d want %0d",
                                got.checked_count, e.checked_count));
    if (got.removed_count !== e.removed_count)
      report_mismatch($sformatf("removed %0d want %0d",
                                got.removed_count, e.removed_count));
    if (got.last !== e.last)
      report_mismatch($sformatf("last %0b want %0b", got.last, e.last));
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    ref_seen = 1'b0;
    cur_ref = '0;
    cur_grp = '1;
    head_cnt = 0;
    heads_checked = '0;
    dups_removed = '0;
  end

  // sample both channels at the edge; results before inputs is harmless since
  // a result never appears in the same cycle its input is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) compare_beat(out_data_i);
      if (in_valid_i && !in_stall_i) predict_filter(in_data_i);
      pending_o = expected_beats.size();
    end
  end
endmodule

[bench/paired_read_duplicate_filter_test.sv]
// Testbench top for the paired-read duplicate filter: clock, reset, stimulus
// and verdict. Checking lives in prdf_checker. Depends on prdf_pkg and the RTL.
`timescale 1ns / 1ps
module paired_read_duplicate_filter_test;
  import prdf_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  logic      hold_rx;      // long receiver hold-off requested
  logic [15:0] cur_ref;
  logic [31:0] cur_pos;
  logic [63:0] name_pool[16];

  paired_read_duplicate_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  prdf_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one beat, holding it until accepted
  task automatic send_beat(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t rec(logic [15:0] r, logic [31:0] p,
                                   logic signed [31:0] d, logic [7:0] sz,
                                   logic [7:0] q, logic [63:0] nm);
    in_item_t it;
    it.mode = 1'b0;
    it.ref_id = r;
    it.pos = p;
    it.dist_req = d;
    it.read_size = sz;
    it.map_quality = q;
    it.name_key = nm;
    it.record_tag = $urandom();
    return it;
  endfunction

  function automatic in_item_t end_beat();
    in_item_t it;
    logic [255:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.mode = 1'b1;
    return it;
  endfunction

  // Random record, mostly well-formed head/tail traffic on a sorted stream
  function automatic in_item_t rand_rec();
    int r;
    logic signed [31:0] d;
    logic [7:0] sz;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      cur_ref = cur_ref + 16'($urandom_range(1, 3));
      cur_pos = $urandom_range(0, 1000);
    end else if (r < 25) begin
      cur_pos = cur_pos + $urandom_range(2, 6);
    end else if (r < 27) begin
      cur_pos = $urandom();   // rare jump, unsorted noise
    end
    sz = 8'($urandom_range(20, 150));
    r = $urandom_range(0, 99);
    if (r < 55) d = 200 + 100 * $urandom_range(0, 1);
    else if (r < 85) d = -($urandom_range(200, 400));
    else if (r < 93) d = $urandom_range(0, sz);
    else d = $urandom();
    return rec(cur_ref, {cur_pos[31:1], 1'($urandom())}, d, sz,
               8'($urandom_range(0, 255)), name_pool[$urandom_range(0, 15)]);
  endfunction

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    int n;
    logic held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (n = 0; n < 300; n++) @(posedge clk_i);
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = gap_len();
        out_stall <= n != 0;
        repeat (n == 0 ? $urandom_range(1, 6) : n) @(posedge clk_i);
      end
    end
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    in_item_t it;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_rx = 1'b0;
    cur_ref = 16'd5;
    cur_pos = 32'd100;
    foreach (name_pool[i]) name_pool[i] = {$urandom(), $urandom()};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unpaired, short distance, duplicate heads, tails, extremes
    send_beat(rec(16'd0, 32'd0, 32'sd0, 8'd0, 8'd0, 64'd0));
    send_beat(rec(16'd0, 32'd0, 32'sd255, 8'd255, 8'd255, '1));
    send_beat(rec(16'd0, 32'd1, 32'sd500, 8'd10, 8'd30, 64'hA1));
    send_beat(rec(16'd0, 32'd1, 32'sd500, 8'd10, 8'd40, 64'hA2));  // replaces
    send_beat(rec(16'd0, 32'd1, 32'sd500, 8'd10, 8'd40, 64'hA3));  // tie: loses
    send_beat(rec(16'd0, 32'd1, 32'sd500, 8'd10, 8'd20, 64'hA3));  // name again
    send_beat(rec(16'd0, 32'd0, 32'sh7fffffff, 8'd0, 8'd1, 64'hB1));
    send_beat(rec(16'd0, 32'd2, -32'sd500, 8'd10, 8'd0, 64'hA1));  // dropped tail
    send_beat(rec(16'd0, 32'd2, 32'sh80000000, 8'd255, 8'd0, 64'hC1));
    send_beat(rec(16'd0, 32'd2, -32'sd7, 8'd7, 8'd0, 64'hA3));
    send_beat(end_beat());
    send_beat(rec(16'hffff, 32'hffffffff, 32'sd900, 8'd1, 8'd5, 64'hD1));
    send_beat(rec(16'hffff, 32'hfffffffe, 32'sd900, 8'd1, 8'd9, 64'hD2));
    send_beat(rec(16'h1234, 32'h55555555, -32'sd1, 8'd0, 8'd0, 64'hD1));
    // fill one group past its depth
    for (int i = 0; i < GROUP_DEPTH_DEF + 2; i++)
      send_beat(rec(16'h1234, 32'h55555554, 32'sd1000 + i, 8'd0, 8'd0, 64'(i)));
    send_beat(end_beat());

    // random with a long receiver hold-off midway and a drain pause
    for (int n = 0; n < 100; n++) begin
      if (n == 40) hold_rx = 1'b1;
      if (n == 90) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 49) == 0) it = end_beat();
      else it = rand_rec();
      send_beat(it);
      if ($urandom_range(0, 2) == 0) send_gap(gap_len());
    end
    send_beat(end_beat());
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
